// ----- rtl/tkdlp_pkg.sv -----
// Package for the two-key touch debounce with long-press detection.
// Holds the shared field widths, the register index codes and the event types.
// Has no dependencies.
package tkdlp_pkg;

  localparam int TIME_W  = 32;
  localparam int TOUCH_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BELOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 3'd4;

  // Event kinds.
  localparam logic ACTION_SHORT = 1'b0;
  localparam logic ACTION_LONG  = 1'b1;

  // Event found by one key lane in one poll.
  typedef struct packed {
    logic               valid;
    logic               action;
    logic [TIME_W-1:0]  duration_ms;
    logic [TOUCH_W-1:0] touch_value;
  } lane_ev_t;

  // One queued result.
  typedef struct packed {
    logic               key;
    logic               action;
    logic [TIME_W-1:0]  duration_ms;
    logic [TOUCH_W-1:0] touch_value;
    logic [TIME_W-1:0]  event_time_ms;
    logic               last;
  } result_t;

endpackage

// ----- rtl/tkdlp_lane.sv -----
// One key lane: threshold compare, debounce and press timing for a single key.
// Depends on tkdlp_pkg for widths and the lane event type.
module tkdlp_lane
  import tkdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               primed,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [TOUCH_W-1:0] sample,
  input  logic [CFG_W-1:0]   level,
  input  logic               active_below,
  input  logic [CFG_W-1:0]   debounce_ms,
  input  logic [CFG_W-1:0]   long_press_ms,
  output lane_ev_t           ev
);

  logic              raw_pressed, raw_pressed_next;
  logic              stable_pressed, stable_pressed_next;
  logic              long_sent, long_sent_next;
  logic [TIME_W-1:0] raw_change_time, raw_change_time_next;
  logic [TIME_W-1:0] press_start_time, press_start_time_next;

  logic              pressed;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] held;
  logic              settle;
  logic              short_ev;
  logic              long_ev;

  // Raw compare, debounce and event decision for this poll.
  always_comb begin
    pressed = active_below ? (sample <= level) : (sample >= level);

    raw_pressed_next     = pressed;
    raw_change_time_next = (pressed != raw_pressed) ? now_ms : raw_change_time;
    since_change         = now_ms - raw_change_time_next;
    settle = (raw_pressed_next != stable_pressed) &&
             (since_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_ms});

    stable_pressed_next   = settle ? raw_pressed_next : stable_pressed;
    press_start_time_next = press_start_time;
    long_sent_next        = long_sent;
    short_ev              = 1'b0;
    if (settle) begin
      if (raw_pressed_next) begin
        press_start_time_next = now_ms;
        long_sent_next        = 1'b0;
      end else if (!long_sent) begin
        short_ev = 1'b1;
      end
    end

    // A short release leaves the start time untouched, so one subtractor serves both kinds.
    held    = now_ms - press_start_time_next;
    long_ev = stable_pressed_next && !long_sent_next &&
              (held >= {{(TIME_W-CFG_W){1'b0}}, long_press_ms});
    if (long_ev) begin
      long_sent_next = 1'b1;
    end

    // The priming poll loads the state from the first sample and reports nothing.
    if (!primed) begin
      raw_pressed_next      = pressed;
      stable_pressed_next   = pressed;
      long_sent_next        = 1'b0;
      raw_change_time_next  = now_ms;
      press_start_time_next = pressed ? now_ms : '0;
      short_ev              = 1'b0;
      long_ev               = 1'b0;
    end

    ev.valid       = short_ev || long_ev;
    ev.action      = long_ev ? ACTION_LONG : ACTION_SHORT;
    ev.duration_ms = held;
    ev.touch_value = sample;
  end

  // Key state advances only on an accepted poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_pressed      <= 1'b0;
      stable_pressed   <= 1'b0;
      long_sent        <= 1'b0;
      raw_change_time  <= '0;
      press_start_time <= '0;
    end else if (fire) begin
      raw_pressed      <= raw_pressed_next;
      stable_pressed   <= stable_pressed_next;
      long_sent        <= long_sent_next;
      raw_change_time  <= raw_change_time_next;
      press_start_time <= press_start_time_next;
    end
  end

endmodule

// ----- rtl/tkdlp_merge.sv -----
// Merging stage: orders the lane events of a poll, marks the last one and queues them.
// Depends on tkdlp_pkg for the event and result types.
module tkdlp_merge
  import tkdlp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [TIME_W-1:0] now_ms,
  input  lane_ev_t          ev_left,
  input  lane_ev_t          ev_right,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_res
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

  result_t       queue [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next, wr_ptr_p1;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count, count_next;

  result_t       first_res, second_res;
  logic          push_one, push_two;
  logic          pop;

  // Left event goes out first; the final event of the poll carries last.
  always_comb begin
    first_res.key           = ev_left.valid ? 1'b0 : 1'b1;
    first_res.action        = ev_left.valid ? ev_left.action : ev_right.action;
    first_res.duration_ms   = ev_left.valid ? ev_left.duration_ms : ev_right.duration_ms;
    first_res.touch_value   = ev_left.valid ? ev_left.touch_value : ev_right.touch_value;
    first_res.event_time_ms = now_ms;
    first_res.last          = !(ev_left.valid && ev_right.valid);

    second_res.key           = 1'b1;
    second_res.action        = ev_right.action;
    second_res.duration_ms   = ev_right.duration_ms;
    second_res.touch_value   = ev_right.touch_value;
    second_res.event_time_ms = now_ms;
    second_res.last          = 1'b1;

    push_one = fire && (ev_left.valid || ev_right.valid);
    push_two = fire && ev_left.valid && ev_right.valid;
    pop      = out_valid && out_ready;

    wr_ptr_p1 = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
    if (push_two) begin
      wr_ptr_next = (wr_ptr_p1 == LAST_SLOT) ? '0 : wr_ptr_p1 + 1'b1;
    end else if (push_one) begin
      wr_ptr_next = wr_ptr_p1;
    end else begin
      wr_ptr_next = wr_ptr;
    end

    count_next = count + CW'(push_one) + CW'(push_two) - CW'(pop);
  end

  assign in_ready  = (count <= ROOM_LIMIT);
  assign out_valid = (count != '0);
  assign out_res   = queue[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push_one) begin
      queue[wr_ptr] <= first_res;
    end
    if (push_two) begin
      queue[wr_ptr_p1] <= second_res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overfilled");

  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    fire |-> count <= ROOM_LIMIT)
    else $error("poll accepted without room for two results");

  a_two_events: assert property (@(posedge clk) disable iff (rst)
    (push_two && !pop) |=> count == $past(count) + CW'(2))
    else $error("two-event poll did not queue two results");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push_one) |=> count == $past(count) - CW'(1))
    else $error("delivered result not removed from queue");

endmodule

// ----- rtl/touch_key_debounce_long_press.sv -----
// Top level of the two-key touch debounce with long-press detection.
// Instantiates tkdlp_lane twice and tkdlp_merge; uses tkdlp_pkg.
//
// Usage:
// - Slave stream carries one poll per transaction:
//   s_axis_tdata = {right_touch, left_touch, now_ms}, now_ms in the lowest bits.
// - Master stream carries one event per transaction; tuser holds key and action,
//   tlast marks the final event of a poll. A poll that yields no event sends nothing.
// - Configuration: cfg_we writes cfg_wdata to register cfg_addr
//   (0 left threshold, 1 right threshold, 2 active below, 3 debounce, 4 long press).
// - Events of an accepted poll are written into the result queue and presented from there.
// - Throughput: one poll per cycle while s_axis_tready is high; the two key lanes work in
//   parallel and the output port, at one event per cycle while m_axis_tready is high, sets
//   the limit, since a poll with events on both keys yields two output events.
// - The result queue holds QUEUE_DEPTH events; s_axis_tready is high while at least
//   two slots are free, so a stalled receiver back-pressures polls without loss.
// - Reset clears all key state and restores the register defaults; the first poll
//   after reset only loads the key state and produces no event.
module touch_key_debounce_long_press
  import tkdlp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // now_ms[31:0], left_touch[47:32], right_touch[63:48]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [79:0]          m_axis_tdata,   // duration_ms[31:0], touch_value[47:32], event_time_ms[79:48]
  output logic [1:0]           m_axis_tuser,   // key[0], action[1]
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] left_threshold;
  logic [CFG_W-1:0] right_threshold;
  logic             active_below;
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic             primed;

  logic               fire;
  logic [TIME_W-1:0]  now_ms;
  logic [TOUCH_W-1:0] left_touch;
  logic [TOUCH_W-1:0] right_touch;
  lane_ev_t           ev_left;
  lane_ev_t           ev_right;
  result_t            res;

  assign now_ms      = s_axis_tdata[31:0];
  assign left_touch  = s_axis_tdata[47:32];
  assign right_touch = s_axis_tdata[63:48];
  assign fire        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_threshold  <= 16'd40;
      right_threshold <= 16'd40;
      active_below    <= 1'b1;
      debounce_ms     <= 16'd30;
      long_press_ms   <= 16'd800;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEFT_THRESHOLD:  left_threshold  <= cfg_wdata;
        REG_RIGHT_THRESHOLD: right_threshold <= cfg_wdata;
        REG_ACTIVE_BELOW:    active_below    <= cfg_wdata[0];
        REG_DEBOUNCE_MS:     debounce_ms     <= cfg_wdata;
        REG_LONG_PRESS_MS:   long_press_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Set by the first accepted poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (fire) begin
      primed <= 1'b1;
    end
  end

  tkdlp_lane u_lane_left (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .primed        (primed),
    .now_ms        (now_ms),
    .sample        (left_touch),
    .level         (left_threshold),
    .active_below  (active_below),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .ev            (ev_left)
  );

  tkdlp_lane u_lane_right (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .primed        (primed),
    .now_ms        (now_ms),
    .sample        (right_touch),
    .level         (right_threshold),
    .active_below  (active_below),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .ev            (ev_right)
  );

  tkdlp_merge #(
    .DEPTH (QUEUE_DEPTH)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .now_ms    (now_ms),
    .ev_left   (ev_left),
    .ev_right  (ev_right),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack the queued result onto the master stream.
  assign m_axis_tdata = {res.event_time_ms, res.touch_value, res.duration_ms};
  assign m_axis_tuser = {res.action, res.key};
  assign m_axis_tlast = res.last;

endmodule
